// ===== sv/thal_pkg.sv =====
// Shared types and constants for the temperature history and alarm block.
// No dependencies; every other source file except thal_ram depends on this package.
package thal_pkg;

    localparam int TEMP_W             = 12;
    localparam int HISTORY_DEPTH      = 256;
    localparam int SAMPLES_PER_RECORD = 101;

    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int CNT_W   = $clog2(SAMPLES_PER_RECORD + 1);
    localparam int SUM_W   = TEMP_W + CNT_W;

    // Divide by SAMPLES_PER_RECORD as multiply by a rounded-up reciprocal,
    // exact for any magnitude below 2**SUM_W.
    localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_RECORD);
    localparam int MUL_W     = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] DIV_MUL =
        MUL_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES_PER_RECORD) - 64'd1)
               / 64'(SAMPLES_PER_RECORD));

    localparam int RUN_W = 2;
    localparam logic [RUN_W-1:0] RUN_TRIGGER = 2'd3;

    localparam logic signed [TEMP_W-1:0] EMPTY_MAX  = -12'sd999;
    localparam logic signed [TEMP_W-1:0] EMPTY_MIN  = 12'sd999;
    localparam logic signed [TEMP_W-1:0] LOW_RESET  = 12'sd0;
    localparam logic signed [TEMP_W-1:0] HIGH_RESET = 12'sd300;

    localparam logic [1:0] ALARM_NONE  = 2'd0;
    localparam logic [1:0] ALARM_HIGH  = 2'd1;
    localparam logic [1:0] ALARM_LOW   = 2'd2;
    localparam logic [1:0] ALARM_ERROR = 2'd3;

    // APB register map: one 32-bit word per register
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_LOW  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HIGH = 1'b1;

    typedef logic signed [TEMP_W-1:0] t_temp;

    typedef struct packed {
        t_temp low_thr;
        t_temp high_thr;
    } t_cfg;

endpackage

// ===== sv/thal_in_if.sv =====
// Input channel: one reading event per item (valid/ready handshake).
// Depends on thal_pkg.
interface thal_in_if;
    logic              valid;
    logic              ready;
    logic              sensor_error;
    thal_pkg::t_temp   probe_temp;
    thal_pkg::t_temp   aux_temp;

    modport source (output valid, sensor_error, probe_temp, aux_temp, input ready);
    modport sink   (input valid, sensor_error, probe_temp, aux_temp, output ready);
endinterface

// ===== sv/thal_out_if.sv =====
// Output channel: one result item per reading (valid/ready handshake).
// Depends on thal_pkg.
interface thal_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        alarm_code;
    thal_pkg::t_temp   history_max;
    thal_pkg::t_temp   history_min;
    logic              record_written;
    logic              readings_valid;
    thal_pkg::t_temp   current_probe;
    thal_pkg::t_temp   current_aux;

    modport source (output valid, alarm_code, history_max, history_min, record_written,
                    readings_valid, current_probe, current_aux, input ready);
    modport sink   (input valid, alarm_code, history_max, history_min, record_written,
                    readings_valid, current_probe, current_aux, output ready);
endinterface

// ===== sv/thal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module thal_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/thal_cfg.sv =====
// APB-style threshold registers (low at 0x0, high at 0x4).
// Depends on thal_pkg.
module thal_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [thal_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output thal_pkg::t_cfg                  o_cfg
);
    import thal_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_thr  <= LOW_RESET;
            r_cfg.high_thr <= HIGH_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LOW:  r_cfg.low_thr  <= pwdata[TEMP_W-1:0];
                REG_HIGH: r_cfg.high_thr <= pwdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LOW:  prdata = 32'(r_cfg.low_thr);
            REG_HIGH: prdata = 32'(r_cfg.high_thr);
            default:  prdata = '0;
        endcase
    end
endmodule

// ===== sv/thal_core.sv =====
// Reading sequencer: run counters, sample accumulator, reciprocal divide,
// ring write and a one-entry-per-cycle min/max rescan of the history RAM.
// Depends on thal_pkg, thal_in_if, thal_out_if, thal_ram.
module thal_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  thal_pkg::t_cfg i_cfg,
    thal_in_if.sink        i_item,
    thal_out_if.source     o_result
);
    import thal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_UPDATE, S_DIV_ABS, S_DIV_MUL, S_DIV_WR, S_SCAN, S_FINISH
    } t_state;

    t_state                   r_state;
    logic                     r_err;
    t_temp                    r_probe, r_aux;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_commit;
    logic [SUM_W-1:0]         r_mag;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_prod;
    logic [SLOT_W-1:0]        r_slot;
    logic [FILL_W-1:0]        r_fill;
    logic [FILL_W-1:0]        r_scan_idx;
    logic                     r_rd_vld;
    logic                     r_first;
    t_temp                    r_max, r_min;
    logic [RUN_W-1:0]         r_high_run, r_low_run, r_err_run;
    logic                     r_held_valid;
    t_temp                    r_held_probe, r_held_aux;
    logic                     r_out_valid;
    logic [1:0]               r_out_alarm;
    t_temp                    r_out_max, r_out_min, r_out_probe, r_out_aux;
    logic                     r_out_wrote, r_out_hvalid;

    logic signed [SUM_W-1:0]  sum_next;
    logic [TEMP_W:0]          q_mag, q_signed;
    t_temp                    quotient;
    t_temp                    rd_data;
    logic                     ram_we;
    logic [1:0]               alarm;

    function automatic logic [RUN_W-1:0] run_up(input logic [RUN_W-1:0] r);
        return (r == RUN_TRIGGER) ? RUN_TRIGGER : r + 1'b1;
    endfunction

    assign sum_next = r_sum + {{(SUM_W-TEMP_W){r_probe[TEMP_W-1]}}, r_probe};
    assign q_mag    = r_prod[DIV_SHIFT +: TEMP_W+1];
    assign q_signed = r_neg ? (~q_mag + 1'b1) : q_mag;
    assign quotient = q_signed[TEMP_W-1:0];
    assign ram_we   = (r_state == S_DIV_WR);

    always_comb begin
        if (r_high_run == RUN_TRIGGER) begin
            alarm = ALARM_HIGH;
        end else if (r_low_run == RUN_TRIGGER) begin
            alarm = ALARM_LOW;
        end else if (r_err_run == RUN_TRIGGER) begin
            alarm = ALARM_ERROR;
        end else begin
            alarm = ALARM_NONE;
        end
    end

    thal_ram #(.WIDTH(TEMP_W), .DEPTH(HISTORY_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (quotient),
        .i_raddr (r_scan_idx[SLOT_W-1:0]),
        .o_rdata (rd_data)
    );

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.alarm_code     = r_out_alarm;
    assign o_result.history_max    = r_out_max;
    assign o_result.history_min    = r_out_min;
    assign o_result.record_written = r_out_wrote;
    assign o_result.readings_valid = r_out_hvalid;
    assign o_result.current_probe  = r_out_probe;
    assign o_result.current_aux    = r_out_aux;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_commit     <= 1'b0;
            r_slot       <= '0;
            r_fill       <= '0;
            r_scan_idx   <= '0;
            r_rd_vld     <= 1'b0;
            r_first      <= 1'b0;
            r_max        <= EMPTY_MAX;
            r_min        <= EMPTY_MIN;
            r_high_run   <= '0;
            r_low_run    <= '0;
            r_err_run    <= '0;
            r_held_valid <= 1'b0;
            r_held_probe <= '0;
            r_held_aux   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // in S_FINISH the output register is reloaded below instead
            if (o_result.valid && o_result.ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_err   <= i_item.sensor_error;
                        r_probe <= i_item.probe_temp;
                        r_aux   <= i_item.aux_temp;
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_commit <= 1'b0;
                    if (r_err) begin
                        r_held_valid <= 1'b0;
                        r_held_probe <= '0;
                        r_held_aux   <= '0;
                        r_err_run    <= run_up(r_err_run);
                        r_state      <= S_FINISH;
                    end else begin
                        r_held_valid <= 1'b1;
                        r_held_probe <= r_probe;
                        r_held_aux   <= r_aux;
                        r_err_run    <= '0;
                        r_low_run    <= (r_probe < i_cfg.low_thr)  ? run_up(r_low_run)  : '0;
                        r_high_run   <= (r_probe > i_cfg.high_thr) ? run_up(r_high_run) : '0;
                        r_sum        <= sum_next;
                        if (r_cnt == CNT_W'(SAMPLES_PER_RECORD - 1)) begin
                            r_cnt    <= '0;
                            r_commit <= 1'b1;
                            r_state  <= S_DIV_ABS;
                        end else begin
                            r_cnt    <= r_cnt + 1'b1;
                            r_state  <= S_FINISH;
                        end
                    end
                end
                S_DIV_ABS: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_mag   <= r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
                    r_sum   <= '0;
                    r_state <= S_DIV_MUL;
                end
                S_DIV_MUL: begin
                    r_prod  <= PROD_W'(r_mag) * PROD_W'(DIV_MUL);
                    r_state <= S_DIV_WR;
                end
                S_DIV_WR: begin
                    r_slot     <= (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                    if (r_fill != FILL_W'(HISTORY_DEPTH)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_scan_idx <= '0;
                    r_rd_vld   <= 1'b0;
                    r_first    <= 1'b1;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    // read issued at idx, data compared in the following cycle
                    if (r_scan_idx != r_fill) begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                        r_rd_vld   <= 1'b1;
                    end else begin
                        r_rd_vld   <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        r_first <= 1'b0;
                        if (r_first || rd_data > r_max) begin
                            r_max <= rd_data;
                        end
                        if (r_first || rd_data < r_min) begin
                            r_min <= rd_data;
                        end
                    end else if (r_scan_idx == r_fill) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_alarm  <= alarm;
                        r_out_max    <= r_max;
                        r_out_min    <= r_min;
                        r_out_wrote  <= r_commit;
                        r_out_hvalid <= r_held_valid;
                        r_out_probe  <= r_held_probe;
                        r_out_aux    <= r_held_aux;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HISTORY_DEPTH))
        else $error("history fill count beyond depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_scan_idx <= r_fill)
        else $error("scan index ran past fill count");

    a_minmax_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_wrote |-> r_out_max >= r_out_min)
        else $error("history max below min after record write");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_hvalid |-> r_out_probe == '0 && r_out_aux == '0)
        else $error("held temperatures nonzero while readings invalid");

    a_commit_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV_WR |=> r_state == S_SCAN && r_fill != '0)
        else $error("record write not followed by rescan");
endmodule

// ===== sv/temperature_history_and_alarm.sv =====
// Temperature history and alarm. One reading item in, one result item out.
// A reading that completes no record passes S_UPDATE and S_FINISH into the
// output register; one that completes a record (every SAMPLES_PER_RECORD
// valid readings) also passes the divide and ring write, then a min/max rescan
// of the N records held (up to 256) in the history RAM, one entry per cycle
// through a single read port. Input ready is high only while the sequencer
// is idle; a finished result waits in the output register while the next
// reading is accepted. Thresholds are written over APB (low at 0x0, high at
// 0x4) only while the block is idle, a rule the block leaves to the user.
// Depends on thal_pkg, thal_in_if, thal_out_if, thal_cfg, thal_core.
module temperature_history_and_alarm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [thal_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    thal_in_if.sink                         i_item,
    thal_out_if.source                      o_result
);
    import thal_pkg::*;

    t_cfg cfg;

    thal_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    thal_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (i_item),
        .o_result (o_result)
    );
endmodule

// ===== tb/temperature_history_and_alarm_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the temperature history and alarm block: keeps its own copy of
// thresholds, history ring and run counters, predicts each result item and compares.
// Depends on thal_pkg, thal_in_if, thal_out_if.
module temperature_history_and_alarm_checker
    import thal_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic [31:0]           prdata,
    input  logic                  pready,
    thal_in_if                    i_item,
    thal_out_if                   i_result,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [1:0] alarm;
        t_temp      hist_max;
        t_temp      hist_min;
        logic       recorded;
        logic       held_ok;
        t_temp      probe;
        t_temp      aux;
    } t_report;

    t_temp                   low_thr;
    t_temp                   high_thr;
    t_temp                   ring [HISTORY_DEPTH];
    bit                      ring_used [HISTORY_DEPTH];
    logic [SLOT_W-1:0]       write_slot;
    logic [CNT_W-1:0]        samples_in;
    logic signed [SUM_W-1:0] sample_sum;
    logic [RUN_W-1:0]        high_run;
    logic [RUN_W-1:0]        low_run;
    logic [RUN_W-1:0]        error_run;
    t_temp                   held_probe;
    t_temp                   held_aux;
    logic                    held_ok;
    t_temp                   max_seen;
    t_temp                   min_seen;
    t_report                 expected_reports [$];
    int                      fails = 0;

    function automatic logic [RUN_W-1:0] bump_run(logic [RUN_W-1:0] r);
        return (r < RUN_TRIGGER) ? r + 1'b1 : RUN_TRIGGER;
    endfunction

    function automatic t_report predict_report(logic err, t_temp probe, t_temp aux);
        t_report rep;
        logic    any;
        t_temp   hi;
        t_temp   lo;
        rep.recorded = 1'b0;
        if (err) begin
            held_ok    = 1'b0;
            held_probe = '0;
            held_aux   = '0;
            error_run  = bump_run(error_run);
        end else begin
            sample_sum = sample_sum + probe;
            samples_in = samples_in + 1'b1;
            if (samples_in >= SAMPLES_PER_RECORD) begin
                // average truncates toward zero
                ring[write_slot]      = t_temp'(int'(sample_sum) / SAMPLES_PER_RECORD);
                ring_used[write_slot] = 1'b1;
                write_slot = (write_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                        : write_slot + 1'b1;
                samples_in   = '0;
                sample_sum   = '0;
                rep.recorded = 1'b1;
                any = 1'b0;
                hi  = EMPTY_MAX;
                lo  = EMPTY_MIN;
                for (int i = 0; i < HISTORY_DEPTH; i++) begin
                    if (ring_used[i]) begin
                        if (!any || ring[i] > hi) hi = ring[i];
                        if (!any || ring[i] < lo) lo = ring[i];
                        any = 1'b1;
                    end
                end
                max_seen = hi;
                min_seen = lo;
            end
            held_ok    = 1'b1;
            held_probe = probe;
            held_aux   = aux;
            error_run  = '0;
            low_run    = (probe < low_thr)  ? bump_run(low_run)  : '0;
            high_run   = (probe > high_thr) ? bump_run(high_run) : '0;
        end
        if (high_run >= RUN_TRIGGER)       rep.alarm = ALARM_HIGH;
        else if (low_run >= RUN_TRIGGER)   rep.alarm = ALARM_LOW;
        else if (error_run >= RUN_TRIGGER) rep.alarm = ALARM_ERROR;
        else                               rep.alarm = ALARM_NONE;
        rep.hist_max = max_seen;
        rep.hist_min = min_seen;
        rep.held_ok  = held_ok;
        rep.probe    = held_probe;
        rep.aux      = held_aux;
        return rep;
    endfunction

    task automatic check_field(string what, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got) begin
            if (fails < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            low_thr    = LOW_RESET;
            high_thr   = HIGH_RESET;
            write_slot = '0;
            samples_in = '0;
            sample_sum = '0;
            high_run   = '0;
            low_run    = '0;
            error_run  = '0;
            held_probe = '0;
            held_aux   = '0;
            held_ok    = 1'b0;
            max_seen   = EMPTY_MAX;
            min_seen   = EMPTY_MIN;
            for (int i = 0; i < HISTORY_DEPTH; i++) ring_used[i] = 1'b0;
            expected_reports.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[APB_ADDR_W-1:2])
                        REG_LOW:  low_thr  = t_temp'(pwdata);
                        REG_HIGH: high_thr = t_temp'(pwdata);
                        default: ;
                    endcase
                end else begin
                    check_field("register readback",
                                (paddr[APB_ADDR_W-1:2] == REG_LOW) ? low_thr : high_thr,
                                t_temp'(prdata));
                end
            end
            if (i_item.valid && i_item.ready)
                expected_reports.push_back(predict_report(i_item.sensor_error,
                                                          i_item.probe_temp,
                                                          i_item.aux_temp));
            if (i_result.valid && i_result.ready) begin
                if (expected_reports.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t: result item with no reading waiting for it", $time);
                    fails++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("alarm_code", want.alarm, i_result.alarm_code);
                    check_field("history_max", want.hist_max, i_result.history_max);
                    check_field("history_min", want.hist_min, i_result.history_min);
                    check_field("record_written", want.recorded, i_result.record_written);
                    check_field("readings_valid", want.held_ok, i_result.readings_valid);
                    check_field("current_probe", want.probe, i_result.current_probe);
                    check_field("current_aux", want.aux, i_result.current_aux);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_reports.size();
    end

endmodule

// ===== tb/temperature_history_and_alarm_tb.sv =====
`timescale 1ns / 100ps
// Top of the temperature history and alarm testbench: clock, reset, APB threshold
// writes, reading stimulus and output stalls; the verdict comes from the scoreboard.
// Depends on thal_pkg, thal_in_if, thal_out_if, the block and its scoreboard module.
module temperature_history_and_alarm_tb;
    import thal_pkg::*;

    localparam int RANDOM_PER_SETTING = 260;
    localparam int N_SETTINGS         = 6;

    typedef enum int {STREAK_MIXED, STREAK_HOT, STREAK_COLD, STREAK_FAULT} t_streak;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    int cur_low       = 0;
    int cur_high      = 300;
    int readings_sent = 0;
    int good_readings = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int stall_span    = 0;
    int stall_style   = 0;
    int stall_tick    = 0;

    thal_in_if  reading_ch ();
    thal_out_if result_ch ();

    temperature_history_and_alarm dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_item(reading_ch), .o_result(result_ch)
    );

    temperature_history_and_alarm_checker alarm_check (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_item(reading_ch), .i_result(result_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    // receiver: switches between free flow, random stalls and a periodic stall
    always @(posedge i_clk) begin
        stall_tick++;
        if (stall_span == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_span  = $urandom_range(16, 200);
        end else begin
            stall_span--;
        end
        case (stall_style)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       result_ch.ready <= (stall_tick % 3 != 0);
            default: result_ch.ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int draw_probe(t_streak s);
        case ($urandom_range(0, 15))
            0: return int'(t_temp'($urandom));
            1: return cur_high;
            2: return cur_low;
            default: ;
        endcase
        if (s == STREAK_HOT && cur_high < 2047) return rand_between(cur_high + 1, 2047);
        if (s == STREAK_COLD && cur_low > -2048) return rand_between(-2048, cur_low - 1);
        return rand_between(-2000, 2000);
    endfunction

    function automatic int draw_aux();
        if ($urandom_range(0, 7) == 0) return int'(t_temp'($urandom));
        return rand_between(-2000, 2000);
    endfunction

    // sender works in bursts; a gap only opens when a burst runs out
    task automatic send_reading(logic err, int probe, int aux);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                reading_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        reading_ch.valid        <= 1'b1;
        reading_ch.sensor_error <= err;
        reading_ch.probe_temp   <= t_temp'(probe);
        reading_ch.aux_temp     <= t_temp'(aux);
        do @(posedge i_clk); while (!reading_ch.ready);
        readings_sent++;
        if (!err) good_readings++;
    endtask

    // hold off until every result is in and the block takes input again
    task automatic drain_results();
        reading_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || !reading_ch.ready);
    endtask

    task automatic apb_access(logic wr, logic [REG_IDX_W-1:0] idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_thresholds(int lo, int hi);
        drain_results();
        apb_access(1'b1, REG_LOW, lo);
        apb_access(1'b1, REG_HIGH, hi);
        apb_access(1'b0, REG_LOW, 0);
        apb_access(1'b0, REG_HIGH, 0);
        cur_low  = lo;
        cur_high = hi;
        settings_used++;
    endtask

    task automatic send_random_readings(int count);
        t_streak streak;
        int      streak_left;
        logic    err;
        streak_left = 0;
        streak      = STREAK_MIXED;
        for (int n = 0; n < count; n++) begin
            if (streak_left == 0) begin
                streak      = t_streak'($urandom_range(0, 3));
                streak_left = $urandom_range(1, 6);
            end
            streak_left--;
            err = (streak == STREAK_FAULT) ? ($urandom_range(0, 7) != 0)
                                           : ($urandom_range(0, 19) == 0);
            send_reading(err, draw_probe(streak), draw_aux());
            if ($urandom_range(0, 199) == 0) drain_results();
        end
    endtask

    // Two records whose averages sit at the ends of the range, then one ordinary
    // record, so max and min reach the extremes with errors mixed in.
    task automatic extreme_records();
        int base;
        while (good_readings % SAMPLES_PER_RECORD != 0)
            send_reading(1'b0, rand_between(-500, 500), draw_aux());
        for (int r = 0; r < 3; r++) begin
            base = (r == 0) ? 2047 : (r == 1) ? -2048 : rand_between(-1700, 1700);
            for (int k = 0; k < SAMPLES_PER_RECORD; k++) begin
                if ($urandom_range(0, 39) == 0)
                    send_reading(1'b1, int'(t_temp'($urandom)), draw_aux());
                send_reading(1'b0, (r < 2) ? base : base + rand_between(-300, 300),
                             draw_aux());
            end
        end
    endtask

    initial begin
        int lows  [N_SETTINGS] = '{-2000, 2047, -2048, -150, 0, 0};
        int highs [N_SETTINGS] = '{2000, -2048, 2047, 150, 0, 300};
        i_rst_n                 <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        reading_ch.valid        <= 1'b0;
        reading_ch.sensor_error <= 1'b0;
        reading_ch.probe_temp   <= '0;
        reading_ch.aux_temp     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain_results();
        apb_access(1'b0, REG_LOW, 0);
        apb_access(1'b0, REG_HIGH, 0);

        // error run, then high run kept across an error, then low beating error
        send_reading(1'b1, 2047, -2048);
        send_reading(1'b1, -2048, 2047);
        send_reading(1'b1, 0, 0);
        send_reading(1'b0, 2047, -2048);
        send_reading(1'b0, 2000, 2000);
        send_reading(1'b0, 301, -2000);
        send_reading(1'b0, 301, 1);
        send_reading(1'b1, 5, 5);
        send_reading(1'b0, 300, 123);
        send_reading(1'b0, -1, -1);
        send_reading(1'b0, -2000, 2047);
        send_reading(1'b0, -2048, -2048);
        send_reading(1'b1, 100, 100);
        send_reading(1'b1, -100, -100);
        send_reading(1'b1, 0, 7);
        send_reading(1'b0, 2047, 0);
        send_reading(1'b0, 2047, 0);
        send_reading(1'b0, 2047, 0);
        send_reading(1'b0, 0, 0);
        send_reading(1'b0, -5, 1365);
        send_reading(1'b0, -5, -1366);
        send_reading(1'b0, -5, 0);

        for (int s = 0; s < N_SETTINGS; s++) begin
            if (s == 4) begin
                lows[s]  = rand_between(-600, 0);
                highs[s] = rand_between(0, 600);
            end
            set_thresholds(lows[s], highs[s]);
            send_random_readings(RANDOM_PER_SETTING);
        end

        set_thresholds(-1000, 1000);
        extreme_records();

        drain_results();
        repeat (HISTORY_DEPTH + 16) @(posedge i_clk);
        $display("Run: %0d readings (%0d valid, %0d history records), %0d threshold settings",
                 readings_sent, good_readings, good_readings / SAMPLES_PER_RECORD,
                 settings_used);
        $display("Covered alarm runs and priorities, crossed and extreme thresholds, "
                 , "records at the ends of the range");
        if (pending != 0) $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("Timed out with %0d results outstanding", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
sv/thal_pkg.sv
sv/thal_in_if.sv
sv/thal_out_if.sv
sv/thal_ram.sv
sv/thal_cfg.sv
sv/thal_core.sv
sv/temperature_history_and_alarm.sv
tb/temperature_history_and_alarm_checker.sv
tb/temperature_history_and_alarm_tb.sv
